@@ rtl/time_window_aggregator_macros.svh @@
// Assertion macros shared by the time window aggregator RTL.
`ifndef TIME_WINDOW_AGGREGATOR_MACROS_SVH
`define TIME_WINDOW_AGGREGATOR_MACROS_SVH
`ifndef SYNTH
`define TWA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWA_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define TWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWA_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ rtl/twa_pkg.sv @@
// Types, constants and codes of the time window aggregator.
`timescale 1ns / 1ps
`default_nettype none
package twa_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned MODE_W  = 3;

  // The magnitude of an average always fits in VAL_W bits.
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM   = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_MIN   = 3'd2,
    MODE_MAX   = 3'd3,
    MODE_COUNT = 3'd4,
    MODE_FIRST = 3'd5,
    MODE_LAST  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    OUTCOME_OK        = 2'd0,
    OUTCOME_EMPTY     = 2'd1,
    OUTCOME_BAD_RANGE = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_WIN_START = 2'd0,
    CFG_WIN_END   = 2'd1,
    CFG_MODE      = 2'd2
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/twa_if.sv @@
// Record and result channel interfaces of the time window aggregator.
`timescale 1ns / 1ps
`default_nettype none
interface twa_rec_if
  import twa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       record_time;
  logic signed [VAL_W-1:0] record_value;
  logic                    end_of_scan;

  modport source (output valid, record_time, record_value, end_of_scan, input ready);
  modport sink   (input valid, record_time, record_value, end_of_scan, output ready);
endinterface

interface twa_res_if
  import twa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] aggregate_result;
  logic [CNT_W-1:0]        matched_count;
  logic [1:0]              outcome;

  modport source (output valid, aggregate_result, matched_count, outcome, input ready);
  modport sink   (input valid, aggregate_result, matched_count, outcome, output ready);
endinterface
`default_nettype wire

@@ rtl/twa_ctrl.sv @@
// Sequencing FSM: record intake, divide steps and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
`include "time_window_aggregator_macros.svh"
module twa_ctrl
  import twa_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  rec_valid_i,
  input  wire  rec_eos_i,
  output logic rec_ready_o,
  output logic res_valid_o,
  input  wire  res_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FINISH,
    S_DIVIDE,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              slot_free;

  assign rec_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || res_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = rec_valid_i && (state_q == S_IDLE);
    cmd_o.div_start = (state_q == S_FINISH) && sts_i.need_div;
    cmd_o.div_step  = (state_q == S_DIVIDE);
    cmd_o.load_out  = (state_q == S_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a taken result may be replaced on the same edge
      out_valid_q <= cmd_o.load_out || (out_valid_q && !res_ready_i);
      case (state_q)
        S_IDLE: begin
          if (rec_valid_i && rec_eos_i) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts_i.need_div) begin
            step_q  <= STEP_W'(DIV_STEPS - 1);
            state_q <= S_DIVIDE;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DIVIDE: begin
          if (step_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a waiting result must never be overwritten
  `TWA_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out |-> (!out_valid_q || res_ready_i), "result overwritten")
  `TWA_ASSERT(a_div_len, clk_i, rst_ni, (state_q == S_FINISH && sts_i.need_div) |-> ##16 (state_q == S_DIVIDE) ##1 (state_q == S_EMIT), "divide length wrong")

endmodule
`default_nettype wire

@@ rtl/twa_dp.sv @@
// Datapath: config registers, window accumulators, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "time_window_aggregator_macros.svh"
module twa_dp
  import twa_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [1:0]              cfg_idx_i,
  input  wire  [CFG_W-1:0]        cfg_wdata_i,
  input  wire  [TIME_W-1:0]       record_time_i,
  input  wire  signed [VAL_W-1:0] record_value_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic signed [RES_W-1:0] aggregate_result_o,
  output logic [CNT_W-1:0]        matched_count_o,
  output logic [1:0]              outcome_o
);

  localparam int unsigned QUO_W = DIV_STEPS;

  logic [TIME_W-1:0] win_start_q, win_end_q;
  logic [MODE_W-1:0] mode_q;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [VAL_W-1:0] low_q, low_d, high_q, high_d;
  logic signed [VAL_W-1:0] first_q, first_d, last_q, last_d;
  logic                    stopped_q, stopped_d;

  logic [SUM_W-1:0] rem_q, dvs_q;
  logic [QUO_W-1:0] quo_q;
  logic             neg_q;

  logic signed [RES_W-1:0] res_q, res_d;
  logic [CNT_W-1:0]        mcnt_q, mcnt_d;
  outcome_e                outcome_q, outcome_d;

  logic bad_range;
  logic [RES_W-1:0] avg_mag;

  assign bad_range = win_start_q > win_end_q;
  assign sts_o.need_div = (mode_q == MODE_AVG) && !bad_range && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '1;
      mode_q      <= MODE_SUM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN_START: win_start_q <= cfg_wdata_i[TIME_W-1:0];
        CFG_WIN_END:   win_end_q   <= cfg_wdata_i[TIME_W-1:0];
        CFG_MODE:      mode_q      <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_d     = sum_q;
    count_d   = count_q;
    low_d     = low_q;
    high_d    = high_q;
    first_d   = first_q;
    last_d    = last_q;
    stopped_d = stopped_q;
    if (cmd_i.load_out) begin
      sum_d     = '0;
      count_d   = '0;
      low_d     = VAL_MAX;
      high_d    = VAL_MIN;
      first_d   = '0;
      last_d    = '0;
      stopped_d = 1'b0;
    end else if (cmd_i.take && !stopped_q && (record_time_i != '0)) begin
      if (record_time_i > win_end_q) begin
        stopped_d = 1'b1;
      end else if ((record_time_i >= win_start_q) && (count_q != COUNT_MAX)) begin
        if (count_q == '0) begin
          first_d = record_value_i;
        end
        last_d  = record_value_i;
        sum_d   = sum_q + SUM_W'(record_value_i);
        count_d = count_q + 1'b1;
        if (record_value_i < low_q) begin
          low_d = record_value_i;
        end
        if (record_value_i > high_q) begin
          high_d = record_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      count_q   <= '0;
      low_q     <= VAL_MAX;
      high_q    <= VAL_MIN;
      first_q   <= '0;
      last_q    <= '0;
      stopped_q <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      count_q   <= count_d;
      low_q     <= low_d;
      high_q    <= high_d;
      first_q   <= first_d;
      last_q    <= last_d;
      stopped_q <= stopped_d;
    end
  end

  // Restoring divide of |sum| by count, one quotient bit per step, MSB first
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      dvs_q <= SUM_W'({count_q, {(QUO_W-1){1'b0}}});
      quo_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  assign avg_mag = RES_W'(quo_q);

  always_comb begin
    res_d     = '0;
    mcnt_d    = '0;
    outcome_d = OUTCOME_OK;
    if (bad_range) begin
      outcome_d = OUTCOME_BAD_RANGE;
    end else if (count_q == '0) begin
      outcome_d = OUTCOME_EMPTY;
    end else begin
      mcnt_d = count_q;
      case (mode_q)
        MODE_SUM:   res_d = sum_q[RES_W-1:0];
        MODE_AVG:   res_d = neg_q ? RES_W'(-avg_mag) : avg_mag;
        MODE_MIN:   res_d = RES_W'(low_q);
        MODE_MAX:   res_d = RES_W'(high_q);
        MODE_COUNT: res_d = count_q;
        MODE_FIRST: res_d = RES_W'(first_q);
        MODE_LAST:  res_d = RES_W'(last_q);
        default:    res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q     <= res_d;
      mcnt_q    <= mcnt_d;
      outcome_q <= outcome_d;
    end
  end

  assign aggregate_result_o = res_q;
  assign matched_count_o    = mcnt_q;
  assign outcome_o          = outcome_q;

  `TWA_ASSERT(a_empty_sum, clk_i, rst_ni, (count_q == '0) |-> (sum_q == '0 && !cmd_i.div_step), "sum without matches")
  `TWA_ASSERT_NEVER(a_min_max, clk_i, rst_ni, (count_q != '0) && (low_q > high_q), "min above max")

endmodule
`default_nettype wire

@@ rtl/time_window_aggregator.sv @@
// Top level of the time window aggregator.
//
//  channel   dir  handshake         payload
//  rec_i     in   valid/ready       record_time, record_value, end_of_scan
//  res_o     out  valid/ready       aggregate_result, matched_count, outcome
//  cfg       in   cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// Records stream at one per cycle while the FSM is idle.
// After end-of-scan the FSM passes FINISH, then EMIT, which loads the result;
// in average mode a 16-step restoring divider makes the quotient in between.
// Records are not taken while the result is being formed.
// One output register holds a result; records keep flowing while it waits,
// and the result of a following scan waits in EMIT until the held one is taken.
// Asynchronous reset restores the register defaults and clears all sums.
`timescale 1ns / 1ps
`default_nettype none
module time_window_aggregator
  import twa_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire  [1:0]       cfg_idx_i,
  input  wire  [CFG_W-1:0] cfg_wdata_i,
  twa_rec_if.sink          rec_i,
  twa_res_if.source        res_o
);

  cmd_t cmd;
  sts_t sts;
  logic rec_ready;
  logic res_valid;

  assign rec_i.ready = rec_ready;
  assign res_o.valid = res_valid;

  twa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_i.valid),
    .rec_eos_i   (rec_i.end_of_scan),
    .rec_ready_o (rec_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  twa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .record_time_i      (rec_i.record_time),
    .record_value_i     (rec_i.record_value),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .aggregate_result_o (res_o.aggregate_result),
    .matched_count_o    (res_o.matched_count),
    .outcome_o          (res_o.outcome)
  );

endmodule
`default_nettype wire

@@ verif/time_window_aggregator_test.sv @@
// Self-checking testbench for the time window aggregator: directed table, then random scans.
`timescale 1ns / 1ps
module time_window_aggregator_test
  import twa_pkg::*;
();

  localparam int unsigned RANDOM_RECORDS = 1100;
  localparam int unsigned SETTLE_CYCLES  = 24;     // longest result latency plus margin
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd7;
  localparam logic [TIME_W-1:0] TIME_LAST    = '1;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [CNT_W-1:0]        count;
    outcome_e                outcome;
  } scan_result_t;

  typedef enum {ROW_RECORD, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    cfg_idx_e                reg_idx;
    logic [CFG_W-1:0]        word;     // timestamp, or register data
    logic signed [VAL_W-1:0] value;
    logic                    eos;
    bit                      typed;
    scan_result_t            want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  twa_rec_if rec_ch ();
  twa_res_if res_ch ();

  time_window_aggregator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rec_i       (rec_ch),
    .res_o       (res_ch)
  );

  always #10 clk = ~clk;

  // Predictor state: configuration copy and the running aggregates of the open scan
  logic [TIME_W-1:0]       win_start_cfg;
  logic [TIME_W-1:0]       win_end_cfg;
  logic [MODE_W-1:0]       mode_cfg;
  logic signed [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0]        acc_count;
  logic signed [VAL_W-1:0] acc_low;
  logic signed [VAL_W-1:0] acc_high;
  logic signed [VAL_W-1:0] acc_first;
  logic signed [VAL_W-1:0] acc_latest;
  logic                    scan_halted;

  scan_result_t pending_results[$];
  plan_row_t    plan[$];

  int unsigned mismatches;
  int unsigned records_sent;
  int unsigned scans_sent;
  int unsigned results_seen;
  int unsigned cycles;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_pending;

  function automatic void clear_scan();
    acc_sum     = '0;
    acc_count   = '0;
    acc_low     = VAL_MAX;
    acc_high    = VAL_MIN;
    acc_first   = '0;
    acc_latest  = '0;
    scan_halted = 1'b0;
  endfunction

  function automatic void fold_record(input logic [TIME_W-1:0] stamp,
                                      input logic signed [VAL_W-1:0] value);
    if (scan_halted || stamp == '0) return;
    if (stamp > win_end_cfg) begin
      scan_halted = 1'b1;
      return;
    end
    if (stamp < win_start_cfg || acc_count == COUNT_MAX) return;
    if (acc_count == '0) acc_first = value;
    acc_latest = value;
    acc_sum    = acc_sum + value;
    acc_count  = acc_count + 1'b1;
    if (value < acc_low) acc_low = value;
    if (value > acc_high) acc_high = value;
  endfunction

  function automatic scan_result_t close_scan();
    scan_result_t r;
    longint       quotient;
    r = '{value: '0, count: '0, outcome: OUTCOME_OK};
    if (win_start_cfg > win_end_cfg) begin
      r.outcome = OUTCOME_BAD_RANGE;
    end else if (acc_count == '0) begin
      r.outcome = OUTCOME_EMPTY;
    end else begin
      r.count = acc_count;
      case (mode_cfg)
        MODE_SUM:   r.value = acc_sum[RES_W-1:0];
        MODE_AVG: begin
          quotient = longint'(acc_sum) / longint'(acc_count);
          r.value  = quotient[RES_W-1:0];
        end
        MODE_MIN:   r.value = RES_W'(acc_low);
        MODE_MAX:   r.value = RES_W'(acc_high);
        MODE_COUNT: r.value = acc_count;
        MODE_FIRST: r.value = RES_W'(acc_first);
        MODE_LAST:  r.value = RES_W'(acc_latest);
        default:    r.value = '0;
      endcase
    end
    clear_scan();
    return r;
  endfunction

  function automatic plan_row_t rec_row(input logic [TIME_W-1:0] stamp,
                                        input logic signed [VAL_W-1:0] value,
                                        input logic eos);
    plan_row_t r;
    r = '{kind: ROW_RECORD, reg_idx: CFG_WIN_START, word: stamp, value: value,
          eos: eos, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t rec_known(input logic [TIME_W-1:0] stamp,
                                          input logic signed [VAL_W-1:0] value,
                                          input logic signed [RES_W-1:0] res_value,
                                          input logic [CNT_W-1:0] res_count,
                                          input outcome_e res_outcome);
    plan_row_t r;
    r = rec_row(stamp, value, 1'b1);
    r.typed = 1'b1;
    r.want  = '{value: res_value, count: res_count, outcome: res_outcome};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    plan_row_t r;
    r = '{kind: ROW_WRITE, reg_idx: idx, word: data, value: '0,
          eos: 1'b0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] pick_stamp();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 8) return '0;
    if (roll < 16 && win_start_cfg != '0) return $urandom_range(win_start_cfg - 1, 0);
    if (roll < 22 && win_end_cfg != TIME_LAST) return $urandom_range(TIME_LAST, win_end_cfg + 1);
    if (roll < 27) return $urandom;
    return $urandom_range(win_end_cfg, win_start_cfg);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(9, 0) == 0) return $urandom_range(1, 0) ? VAL_MAX : VAL_MIN;
    return VAL_W'($urandom);
  endfunction

  // Registers change only with the block idle: no request in flight, divider finished.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    if (!cfg_we) begin
      rec_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WIN_START: win_start_cfg = data[TIME_W-1:0];
      CFG_WIN_END:   win_end_cfg   = data[TIME_W-1:0];
      CFG_MODE:      mode_cfg      = data[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_record(input logic [TIME_W-1:0] stamp,
                             input logic signed [VAL_W-1:0] value,
                             input logic eos, input bit typed, input scan_result_t want);
    int unsigned  gap;
    scan_result_t got;
    gap = tx_steady ? 0 : $urandom_range(11, 0);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_ch.valid        <= 1'b1;
    rec_ch.record_time  <= stamp;
    rec_ch.record_value <= value;
    rec_ch.end_of_scan  <= eos;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
    fold_record(stamp, value);
    records_sent++;
    if (eos) begin
      got = close_scan();
      pending_results.push_back(typed ? want : got);
      scans_sent++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned  stall;
    int unsigned  held;
    scan_result_t want;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        res_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(11, 0);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: aggregate_result %0d", res_ch.aggregate_result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.aggregate_result !== want.value) begin
          $error("aggregate_result: expected %0d, got %0d", want.value,
                 res_ch.aggregate_result);
          mismatches++;
        end
        if (res_ch.matched_count !== want.count) begin
          $error("matched_count: expected %0d, got %0d", want.count, res_ch.matched_count);
          mismatches++;
        end
        if (res_ch.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, res_ch.outcome);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned       random_base;
    int unsigned       phases;
    int unsigned       shape;
    int unsigned       n_scans;
    int unsigned       len;
    int unsigned       roll;
    int unsigned       k;
    bit                squeeze;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_WIN_START;
    cfg_wdata           <= '0;
    rec_ch.valid        <= 1'b0;
    rec_ch.record_time  <= '0;
    rec_ch.record_value <= '0;
    rec_ch.end_of_scan  <= 1'b0;
    win_start_cfg = '0;
    win_end_cfg   = TIME_LAST;
    mode_cfg      = MODE_SUM;
    clear_scan();
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_pending = 1'b0;
    records_sent = 0;
    scans_sent   = 0;
    phases       = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = '{
      // register defaults: lone end-of-scan on an empty slot, then both value extremes
      rec_known(32'd0, 16'sd0, 0, 0, OUTCOME_EMPTY),
      rec_row(32'd1, VAL_MAX, 1'b0),
      rec_row(TIME_LAST, VAL_MIN, 1'b0),
      rec_known(32'd0, 16'sd1234, -1, 2, OUTCOME_OK),
      // average of a negative sum truncates toward zero
      cfg_row(CFG_MODE, MODE_AVG),
      rec_row(32'd5, -16'sd7, 1'b0),
      rec_row(32'd6, -16'sd2, 1'b1),
      cfg_row(CFG_MODE, MODE_MIN),
      rec_row(32'd9, VAL_MAX, 1'b0),
      rec_known(32'd10, VAL_MIN, -32768, 2, OUTCOME_OK),
      cfg_row(CFG_MODE, MODE_MAX),
      rec_known(32'd9, VAL_MIN, -32768, 1, OUTCOME_OK),
      // window edges, empty slot inside, stop past the end, later records ignored
      cfg_row(CFG_MODE, MODE_COUNT),
      cfg_row(CFG_WIN_START, 32'd100),
      cfg_row(CFG_WIN_END, 32'd200),
      rec_row(32'd50, 16'sd3, 1'b0),
      rec_row(32'd100, 16'sd11, 1'b0),
      rec_row(32'd0, 16'sd99, 1'b0),
      rec_row(32'd200, -16'sd5, 1'b0),
      rec_row(32'd201, 16'sd8, 1'b0),
      rec_row(32'd150, 16'sd4, 1'b1),
      cfg_row(CFG_MODE, MODE_FIRST),
      rec_row(32'd120, 16'sd21, 1'b0),
      rec_row(32'd130, -16'sd22, 1'b1),
      cfg_row(CFG_MODE, MODE_LAST),
      rec_row(32'd120, 16'sd21, 1'b0),
      rec_row(32'd130, -16'sd22, 1'b1),
      cfg_row(CFG_MODE, MODE_UNKNOWN),
      rec_row(32'd150, 16'sd6, 1'b1),
      // start after end, then an end of zero that halts on any stamped record
      cfg_row(CFG_WIN_START, 32'd300),
      rec_known(32'd250, 16'sd1, 0, 0, OUTCOME_BAD_RANGE),
      cfg_row(CFG_WIN_START, 32'd0),
      cfg_row(CFG_WIN_END, 32'd0),
      rec_known(32'd1, 16'sd5, 0, 0, OUTCOME_EMPTY)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].word);
      end else begin
        send_record(plan[i].word, plan[i].value, plan[i].eos, plan[i].typed, plan[i].want);
      end
    end

    random_base = records_sent;
    while (records_sent - random_base < RANDOM_RECORDS) begin
      shape = $urandom_range(9, 0);
      lo    = $urandom;
      hi    = $urandom;
      case (shape)
        1, 2: hi = (lo > TIME_LAST - 4000) ? TIME_LAST : lo + $urandom_range(4000, 0);
        3: begin
          lo = TIME_LAST;
          hi = TIME_LAST;
        end
        4: begin
          lo = $urandom_range(TIME_LAST, 1);
          hi = $urandom_range(lo - 1, 0);
        end
        5: begin
          lo = '0;
          hi = '0;
        end
        6: if (lo > hi) begin
          lo = hi;
          hi = $urandom_range(TIME_LAST, lo);
        end
        7: lo = '0;
        default: begin
          lo = '0;
          hi = TIME_LAST;
        end
      endcase
      write_reg(CFG_WIN_START, lo);
      write_reg(CFG_WIN_END, hi);
      write_reg(CFG_MODE, $urandom_range(7, 0));

      tx_steady = ($urandom_range(3, 0) == 0);
      rx_steady = ($urandom_range(3, 0) == 0);
      // first random phase: hold results off while short scans pile up behind them
      squeeze = (phases == 0);
      if (squeeze) begin
        hold_pending = 1'b1;
        tx_steady    = 1'b1;
      end
      n_scans = squeeze ? 16 : $urandom_range(10, 3);

      repeat (n_scans) begin
        roll = $urandom_range(99, 0);
        if (squeeze) len = $urandom_range(2, 1);
        else if (roll < 80) len = $urandom_range(8, 1);
        else if (roll < 95) len = $urandom_range(20, 9);
        else len = $urandom_range(40, 21);
        for (k = 1; k <= len; k++) begin
          send_record(pick_stamp(), pick_value(), k == len, 1'b0, '0);
        end
      end
      phases++;
    end

    rec_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d record requests in %0d scans over %0d random window settings;",
             records_sent, scans_sent, phases);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ time_window_aggregator.f @@
+incdir+rtl
rtl/twa_pkg.sv
rtl/twa_if.sv
rtl/twa_ctrl.sv
rtl/twa_dp.sv
rtl/time_window_aggregator.sv
verif/time_window_aggregator_test.sv
